FILE: design/agbg_pkg.sv
// Package for the adaptive GPU budget governor.
// Holds the request and response payload types and the fixed limits.
// No dependencies; used by the channel interfaces and the top level.
package agbg_pkg;

  // Field widths.
  localparam int unsigned DurW     = 16;
  localparam int unsigned BudgetW  = 13;
  localparam int unsigned FaceW    = 3;
  localparam int unsigned SamplesW = 7;
  localparam int unsigned CountW   = 2;

  // Budget register limits and reset value, Q5.8 milliseconds.
  localparam logic [BudgetW-1:0] BudgetMin   = 13'd26;
  localparam logic [BudgetW-1:0] BudgetMax   = 13'd4096;
  localparam logic [BudgetW-1:0] BudgetReset = 13'd512;

  // Face budget and filter sample limits.
  localparam logic [FaceW-1:0]    FaceMax    = 3'd6;
  localparam logic [FaceW-1:0]    FaceMin    = 3'd1;
  localparam logic [SamplesW-1:0] SamplesMax = 7'd64;
  localparam logic [SamplesW-1:0] SamplesMin = 7'd8;

  // Last value of the under-budget count before a run of four completes.
  localparam logic [CountW-1:0] UnderRunLast = 2'd3;

  // Reciprocal of five scaled by 2^21, exact for dividends below 699050.
  localparam int unsigned        Div5Shift = 21;
  localparam int unsigned        SumW      = DurW + 3;
  localparam logic [SumW-1:0]    Div5Recip = 19'd419431;

  // One request: a measured GPU duration.
  typedef struct packed {
    logic [DurW-1:0] duration_ms_q8;
  } req_t;

  // One response: the governor's decisions after a request.
  typedef struct packed {
    logic [FaceW-1:0]    face_budget;
    logic [SamplesW-1:0] filter_samples;
    logic [DurW-1:0]     smoothed_ms_q8;
    logic                over_budget;
    logic                sample_used;
  } rsp_t;

endpackage

FILE: design/agbg_req_if.sv
// Request channel of the adaptive GPU budget governor.
// Valid/ready handshake carrying one agbg_pkg::req_t; depends on agbg_pkg.
interface agbg_req_if;
  import agbg_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/agbg_rsp_if.sv
// Response channel of the adaptive GPU budget governor.
// Valid/ready handshake carrying one agbg_pkg::rsp_t; depends on agbg_pkg.
interface agbg_rsp_if;
  import agbg_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/adaptive_gpu_budget_governor.sv
// Adaptive GPU budget governor: top level.
// Smooths reported GPU durations and steers face budget and filter samples.
// Depends on agbg_pkg, agbg_req_if and agbg_rsp_if.
//
// Usage: each request on req_i carries one measured GPU duration in Q8.8
// milliseconds; a zero duration is ignored and only reports the current
// state. Every request yields exactly one response on rsp_o with the face
// budget, filter sample count, smoothed duration and two status flags.
// The budget register is written through budget_we_i / budget_wdata_i; the user
// must write it only while no request is in flight, which the block does not enforce.
// The value is clamped to 26..4096 and the under-budget run count is cleared.
// A request is captured in the input register; from there the smoothing
// divide, threshold compares and limit updates are done in one pass into
// the response register. Throughput is one request per cycle while the
// receiver does not stall, set by the state feedback through that pass.
// When the receiver stalls, the response register holds its request and
// the input register takes one more; further requests then wait.
// Reset returns the budget to 2 ms, the smoothed value to zero, the face
// budget to six, the filter samples to 64 and empties both registers.
module adaptive_gpu_budget_governor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  agbg_req_if.sink                     req_i,
  agbg_rsp_if.source                   rsp_o,
  input  logic                         budget_we_i,
  input  logic [agbg_pkg::BudgetW-1:0] budget_wdata_i
);
  import agbg_pkg::*;

  // Input register and response register.
  logic              in_valid_q;
  logic [DurW-1:0]   in_dur_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q, rsp_d;

  // Governor state.
  logic [BudgetW-1:0]  budget_q, budget_d;
  logic [DurW-1:0]     smoothed_q, smoothed_d;
  logic [CountW-1:0]   under_count_q, under_count_d;
  logic [FaceW-1:0]    face_q, face_d;
  logic [SamplesW-1:0] samples_q, samples_d;

  logic                out_free;
  logic                advance;
  logic                used;
  logic                over;
  logic                under;
  logic [SumW-1:0]     sum;
  logic [2*SumW-1:0]   prod;
  logic [DurW-1:0]     quot;
  logic [DurW+3:0]     s10;
  logic [DurW+3:0]     b11;
  logic [DurW+3:0]     b7;

  // Handshake: the input register moves on whenever the response slot frees.
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // Clamp a budget write into the legal range.
  always_comb begin
    budget_d = budget_q;
    if (budget_we_i) begin
      if (budget_wdata_i < BudgetMin) begin
        budget_d = BudgetMin;
      end else if (budget_wdata_i > BudgetMax) begin
        budget_d = BudgetMax;
      end else begin
        budget_d = budget_wdata_i;
      end
    end
  end

  // Smoothing: (4*s + m) / 5 by reciprocal multiply, first sample loaded.
  assign used = (in_dur_q != '0);
  assign sum  = {1'b0, smoothed_q, 2'b00} + SumW'(in_dur_q);
  assign prod = (2*SumW)'(sum) * (2*SumW)'(Div5Recip);
  assign quot = prod[Div5Shift+DurW-1:Div5Shift];

  always_comb begin
    if (!used) begin
      smoothed_d = smoothed_q;
    end else if (smoothed_q == '0) begin
      smoothed_d = in_dur_q;
    end else begin
      smoothed_d = quot;
    end
  end

  // Threshold compares against 1.1 and 0.7 times the budget.
  assign s10   = {2'b00, smoothed_d, 2'b00} + {1'b0, smoothed_d, 3'b000} - {4'b0000, smoothed_d}
                 - {4'b0000, smoothed_d};
  assign b11   = (DurW+4)'(budget_q) * (DurW+4)'(11);
  assign b7    = (DurW+4)'(budget_q) * (DurW+4)'(7);
  assign over  = used && (s10 > b11);
  assign under = used && !over && (s10 < b7);

  // Face budget, filter samples and the under-budget run count.
  always_comb begin
    face_d        = face_q;
    samples_d     = samples_q;
    under_count_d = under_count_q;
    if (used) begin
      if (over) begin
        under_count_d = '0;
        if (face_q > FaceMin) begin
          face_d = face_q - FaceW'(1);
        end else if (samples_q > SamplesMin) begin
          samples_d = samples_q >> 1;
        end
      end else if (under) begin
        if (under_count_q != UnderRunLast) begin
          under_count_d = under_count_q + CountW'(1);
        end else begin
          under_count_d = '0;
          if (samples_q < SamplesMax) begin
            samples_d = samples_q << 1;
          end else if (face_q < FaceMax) begin
            face_d = face_q + FaceW'(1);
          end
        end
      end else begin
        under_count_d = '0;
      end
    end
  end

  // Response payload as seen after this request.
  always_comb begin
    rsp_d.face_budget    = face_d;
    rsp_d.filter_samples = samples_d;
    rsp_d.smoothed_ms_q8 = smoothed_d;
    rsp_d.over_budget    = over;
    rsp_d.sample_used    = used;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      rsp_valid_q   <= 1'b0;
      budget_q      <= BudgetReset;
      smoothed_q    <= '0;
      under_count_q <= '0;
      face_q        <= FaceMax;
      samples_q     <= SamplesMax;
    end else begin
      budget_q <= budget_d;
      if (req_i.valid && req_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
        smoothed_q  <= smoothed_d;
        face_q      <= face_d;
        samples_q   <= samples_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      // A budget write restarts the under-budget run.
      if (budget_we_i) begin
        under_count_q <= '0;
      end else if (advance) begin
        under_count_q <= under_count_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_dur_q <= req_i.payload.duration_ms_q8;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The face budget stays within one to six.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (face_q >= FaceMin) && (face_q <= FaceMax))
    else $error("face budget out of range");

  // The filter sample count is a power of two from eight upwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(samples_q) && (samples_q[2:0] == 3'b000))
    else $error("filter sample count not a power of two of at least eight");

  // The stored budget always lies within its clamped range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (budget_q >= BudgetMin) && (budget_q <= BudgetMax))
    else $error("budget register out of range");

  // A budget write clears the under-budget run count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    budget_we_i |=> (under_count_q == '0))
    else $error("under-budget count not cleared by budget write");

  // An over-budget response always comes from a used sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.over_budget |-> rsp_q.sample_used)
    else $error("over budget flagged on an ignored sample");
`endif

endmodule
